// ===== hdl/spq_pkg.sv =====
// Package for the stable priority queue with waiting-time report.
// Holds field widths, opcodes, the controller state type and default depth.
// No dependencies.
package spq_pkg;

  localparam int OP_W     = 2;
  localparam int TIME_W   = 16;
  localparam int PRIO_W   = 8;
  localparam int WAIT_W   = 20;
  localparam int ENTRY_W  = TIME_W + PRIO_W;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam logic [OP_W-1:0]   OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0]   OP_POP   = 2'd1;
  localparam logic [WAIT_W-1:0] WAIT_MAX = 20'hFFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_INS,
    ST_POPRD,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/spq_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Width and depth are parameters. No dependencies.
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/stable_priority_queue_with_wait_time.sv =====
// Top level of the stable priority queue with waiting-time report.
// Depends on spq_pkg and spq_ram.
//
//  Channel  Ports                                           Flow control
//  -------  ----------------------------------------------  ------------
//  input    in_opcode, in_item_time, in_item_priority        in_valid / in_stall
//  output   out_popped_time, out_waiting_time, out_head_time,
//           out_is_empty, out_op_error                       out_valid / out_stall
//
// Entries sit in one RAM as a circular buffer. A push walks backward from the
// tail with one RAM read per cycle, shifting each entry of higher priority up by
// one; a pop that leaves an entry reads it to become the new head time. Reset
// clears only the state, the count, the head pointer, the running total, the
// head time and the output valid flag; no clearing pass is needed. A stalled
// output holds the finished transaction while the next transaction is already
// accepted and worked on.
module stable_priority_queue_with_wait_time
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [TIME_W-1:0] in_item_time,
  input  logic [PRIO_W-1:0] in_item_priority,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [TIME_W-1:0] out_popped_time,
  output logic [WAIT_W-1:0] out_waiting_time,
  output logic [TIME_W-1:0] out_head_time,
  output logic              out_is_empty,
  output logic              out_op_error
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = TIME_W + CW;
  localparam int SW = TW + WAIT_W + 1;

  state_t state_r, state_nxt;

  logic [OP_W-1:0]   op_r, op_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic [PW-1:0]     k_r, k_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [PW-1:0]     head_r, head_nxt;
  logic [TW-1:0]     total_r, total_nxt;
  logic [TW-1:0]     shifted_r, shifted_nxt;
  logic [TIME_W-1:0] head_time_r, head_time_nxt;
  logic [TIME_W-1:0] res_popped_r, res_popped_nxt;
  logic [WAIT_W-1:0] res_wait_r, res_wait_nxt;
  logic              res_err_r, res_err_nxt;

  logic              out_valid_r;
  logic [TIME_W-1:0] out_popped_r;
  logic [WAIT_W-1:0] out_wait_r;
  logic [TIME_W-1:0] out_head_r;
  logic              out_empty_r;
  logic              out_err_r;

  logic               in_acc;
  logic               out_free;
  logic               ram_we;
  logic [PW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [PW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [TIME_W-1:0]  rd_time;
  logic [PRIO_W-1:0]  rd_prio;
  logic [CW-1:0]      cnt_m1;
  logic               is_full;
  logic               is_zero;
  logic [SW-1:0]      wsum;
  logic [WAIT_W-1:0]  wait_sat;

  function automatic logic [PW-1:0] phys(input logic [PW-1:0] head, input logic [PW-1:0] l);
    logic [PW:0] s;
    s = {1'b0, head} + {1'b0, l};
    if (s >= (PW+1)'(QUEUE_DEPTH)) begin
      s = s - (PW+1)'(QUEUE_DEPTH);
    end
    return s[PW-1:0];
  endfunction

  spq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_time  = ram_rdata[TIME_W-1:0];
  assign rd_prio  = ram_rdata[TIME_W +: PRIO_W];
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign cnt_m1   = count_r - 1'b1;
  assign is_full  = (count_r == CW'(QUEUE_DEPTH));
  assign is_zero  = (count_r == '0);

  assign wsum = SW'(total_r) - SW'(shifted_r) + SW'(time_r);
  assign wait_sat = (wsum > SW'(WAIT_MAX)) ? WAIT_MAX : wsum[WAIT_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_PUSH) begin
            if (is_full) begin
              state_nxt = ST_DONE;
            end else if (is_zero) begin
              state_nxt = ST_INS;
            end else begin
              state_nxt = ST_WALK;
            end
          end else if (in_opcode == OP_POP) begin
            if (count_r > CW'(1)) begin
              state_nxt = ST_POPRD;
            end else begin
              state_nxt = ST_DONE;
            end
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        if (rd_prio > prio_r) begin
          state_nxt = (k_r == '0) ? ST_INS : ST_WALK;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_INS:   state_nxt = ST_DONE;
      ST_POPRD: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    op_nxt         = op_r;
    time_nxt       = time_r;
    prio_nxt       = prio_r;
    k_nxt          = k_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    total_nxt      = total_r;
    shifted_nxt    = shifted_r;
    head_time_nxt  = head_time_r;
    res_popped_nxt = res_popped_r;
    res_wait_nxt   = res_wait_r;
    res_err_nxt    = res_err_r;
    ram_we         = 1'b0;
    ram_waddr      = phys(head_r, k_r + 1'b1);
    ram_wdata      = {prio_r, time_r};
    ram_raddr      = phys(head_r, k_r - 1'b1);
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt         = in_opcode;
          time_nxt       = in_item_time;
          prio_nxt       = in_item_priority;
          shifted_nxt    = '0;
          res_popped_nxt = '0;
          res_wait_nxt   = '0;
          res_err_nxt    = 1'b0;
          k_nxt          = cnt_m1[PW-1:0];
          if (in_opcode == OP_PUSH) begin
            ram_raddr   = phys(head_r, cnt_m1[PW-1:0]);
            res_err_nxt = is_full;
          end else if (in_opcode == OP_POP) begin
            ram_raddr = phys(head_r, PW'(1));
            if (is_zero) begin
              res_err_nxt = 1'b1;
            end else begin
              res_popped_nxt = head_time_r;
              head_nxt       = phys(head_r, PW'(1));
              count_nxt      = cnt_m1;
              total_nxt      = total_r - TW'(head_time_r);
              if (count_r == CW'(1)) begin
                head_time_nxt = '0;
              end
            end
          end
        end
      end
      ST_WALK: begin
        ram_we = 1'b1;
        if (rd_prio > prio_r) begin
          ram_wdata   = ram_rdata;
          shifted_nxt = shifted_r + TW'(rd_time);
          k_nxt       = k_r - 1'b1;
        end else begin
          count_nxt    = count_r + 1'b1;
          total_nxt    = total_r + TW'(time_r);
          res_wait_nxt = wait_sat;
        end
      end
      ST_INS: begin
        ram_we        = 1'b1;
        ram_waddr     = head_r;
        count_nxt     = count_r + 1'b1;
        total_nxt     = total_r + TW'(time_r);
        res_wait_nxt  = wait_sat;
        head_time_nxt = time_r;
      end
      ST_POPRD: begin
        head_time_nxt = rd_time;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      total_r     <= '0;
      head_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      head_time_r <= head_time_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    time_r       <= time_nxt;
    prio_r       <= prio_nxt;
    k_r          <= k_nxt;
    shifted_r    <= shifted_nxt;
    res_popped_r <= res_popped_nxt;
    res_wait_r   <= res_wait_nxt;
    res_err_r    <= res_err_nxt;
    if (state_r == ST_DONE && out_free) begin
      out_popped_r <= res_popped_r;
      out_wait_r   <= res_wait_r;
      out_head_r   <= head_time_r;
      out_empty_r  <= is_zero;
      out_err_r    <= res_err_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_time  = out_popped_r;
  assign out_waiting_time = out_wait_r;
  assign out_head_time    = out_head_r;
  assign out_is_empty     = out_empty_r;
  assign out_op_error     = out_err_r;

  // The count never exceeds the queue depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  // An empty queue reports a zero head time.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_head_r == '0)
    else $error("empty queue reports nonzero head time");

  // A rejected transaction reports neither a popped time nor a waiting time.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_popped_r == '0 && out_wait_r == '0)
    else $error("rejected transaction reports a time");

  // The RAM is written only while a push is being placed.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_WALK || state_r == ST_INS) && op_r == OP_PUSH)
    else $error("RAM written outside a push");

endmodule

// ===== sim/stable_priority_queue_with_wait_time_tb.sv =====
// Self-checking testbench for the stable priority queue with waiting-time report.
// Depends on spq_pkg and the stable_priority_queue_with_wait_time top level;
// a sorted-insertion model predicts every result under random idling on both sides.
`timescale 1ns / 100ps

module stable_priority_queue_with_wait_time_tb;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
  localparam logic [OP_W-1:0] OP_STATUS = 2'd2;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 1930;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTED = 30;

  typedef struct packed {
    logic [TIME_W-1:0] popped_time;
    logic [WAIT_W-1:0] waiting_time;
    logic [TIME_W-1:0] head_time;
    logic is_empty;
    logic op_error;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_opcode = OP_STATUS;
  logic [TIME_W-1:0] in_item_time = '0;
  logic [PRIO_W-1:0] in_item_priority = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TIME_W-1:0] out_popped_time;
  logic [WAIT_W-1:0] out_waiting_time;
  logic [TIME_W-1:0] out_head_time;
  logic out_is_empty;
  logic out_op_error;

  logic [TIME_W-1:0] model_time [QUEUE_DEPTH];
  logic [PRIO_W-1:0] model_prio [QUEUE_DEPTH];
  int model_count = 0;
  queue_result_t pending_results[$];

  int error_count = 0;
  int cycle_count = 0;
  int results_seen = 0;
  int pushes_seen = 0;
  int pops_seen = 0;
  int status_seen = 0;
  int full_hits = 0;
  int empty_hits = 0;
  int max_fill = 0;
  bit send_idle_on = 1'b1;
  bit stall_idle_on = 1'b1;

  stable_priority_queue_with_wait_time #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_item_time(in_item_time),
    .in_item_priority(in_item_priority),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_popped_time(out_popped_time),
    .out_waiting_time(out_waiting_time),
    .out_head_time(out_head_time),
    .out_is_empty(out_is_empty),
    .out_op_error(out_op_error)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("MISMATCH cycle %0d result %0d: %s", cycle_count, results_seen, what);
    end
  endtask

  task automatic check_field(input string name, input logic [WAIT_W-1:0] got,
                             input logic [WAIT_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  // Sorted insertion after all entries of equal or better priority.
  function automatic queue_result_t predict_queue_op(input logic [OP_W-1:0] op,
                                                     input logic [TIME_W-1:0] t,
                                                     input logic [PRIO_W-1:0] p);
    queue_result_t r;
    logic [WAIT_W:0] acc;
    int slot;
    int idx;
    r = '0;
    acc = '0;
    slot = 0;
    if (op == OP_PUSH) begin
      pushes_seen++;
      if (model_count >= QUEUE_DEPTH) begin
        r.op_error = 1'b1;
        full_hits++;
      end else begin
        while (slot < model_count && p >= model_prio[slot]) begin
          acc = acc + model_time[slot];
          if (acc > {1'b0, WAIT_MAX}) acc = {1'b0, WAIT_MAX};
          slot++;
        end
        acc = acc + t;
        if (acc > {1'b0, WAIT_MAX}) acc = {1'b0, WAIT_MAX};
        r.waiting_time = acc[WAIT_W-1:0];
        for (idx = model_count; idx > slot; idx--) begin
          model_time[idx] = model_time[idx-1];
          model_prio[idx] = model_prio[idx-1];
        end
        model_time[slot] = t;
        model_prio[slot] = p;
        model_count++;
        if (model_count > max_fill) max_fill = model_count;
      end
    end else if (op == OP_POP) begin
      pops_seen++;
      if (model_count == 0) begin
        r.op_error = 1'b1;
        empty_hits++;
      end else begin
        r.popped_time = model_time[0];
        for (idx = 1; idx < model_count; idx++) begin
          model_time[idx-1] = model_time[idx];
          model_prio[idx-1] = model_prio[idx];
        end
        model_count--;
      end
    end else begin
      status_seen++;
    end
    r.head_time = (model_count > 0) ? model_time[0] : '0;
    r.is_empty = (model_count == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with no transaction outstanding");
      end else begin
        check_field("popped_time", WAIT_W'(out_popped_time),
                    WAIT_W'(pending_results[0].popped_time));
        check_field("waiting_time", out_waiting_time, pending_results[0].waiting_time);
        check_field("head_time", WAIT_W'(out_head_time),
                    WAIT_W'(pending_results[0].head_time));
        check_field("is_empty", WAIT_W'(out_is_empty),
                    WAIT_W'(pending_results[0].is_empty));
        check_field("op_error", WAIT_W'(out_op_error),
                    WAIT_W'(pending_results[0].op_error));
        void'(pending_results.pop_front());
      end
      results_seen++;
    end
  end

  initial begin : result_stall
    int hold;
    forever begin
      hold = stall_idle_on ? $urandom_range(0, 10) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic issue_request(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] t,
                               input logic [PRIO_W-1:0] p);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_item_time <= t;
    in_item_priority <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_queue_op(op, t, p));
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_queue();
    issue_request(OP_POP, 16'hFFFF, 8'hFF);
    issue_request(OP_STATUS, 16'hFFFF, 8'hFF);
    issue_request(OP_SPARE, 16'h1234, 8'h56);
    issue_request(OP_POP, 16'h0000, 8'h00);
  endtask

  task automatic test_stable_ordering();
    issue_request(OP_PUSH, 16'd100, 8'd5);
    issue_request(OP_PUSH, 16'd200, 8'd5);
    issue_request(OP_PUSH, 16'hFFFF, 8'd0);
    issue_request(OP_PUSH, 16'd0, 8'hFF);
    issue_request(OP_PUSH, 16'd7, 8'd5);
    issue_request(OP_PUSH, 16'd1, 8'd4);
    issue_request(OP_STATUS, 16'hAAAA, 8'h55);
    repeat (6) issue_request(OP_POP, 16'h5555, 8'hAA);
    issue_request(OP_POP, 16'd0, 8'd0);
    issue_request(OP_SPARE, 16'hFFFF, 8'hFF);
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    int sent;
    int burst_len;
    int push_pct;
    int prio_style;
    int roll;
    bit heavy;
    logic [OP_W-1:0] op;
    logic [TIME_W-1:0] t;
    logic [PRIO_W-1:0] p;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(30, 120);
      case ($urandom_range(0, 2))
        0: push_pct = 85;
        1: push_pct = 50;
        default: push_pct = 20;
      endcase
      prio_style = $urandom_range(0, 2);
      heavy = ($urandom_range(0, 5) == 0);
      send_idle_on = ($urandom_range(0, 3) != 0);
      stall_idle_on = ($urandom_range(0, 3) != 0);
      repeat (burst_len) begin
        roll = $urandom_range(0, 99);
        if (roll >= 94) op = (roll[0]) ? OP_SPARE : OP_STATUS;
        else if (roll < push_pct) op = OP_PUSH;
        else op = OP_POP;
        case ($urandom_range(0, 7))
          0: t = '0;
          1: t = '1;
          default: t = TIME_W'($urandom);
        endcase
        if (heavy) t = '1;
        case (prio_style)
          0: p = PRIO_W'($urandom_range(0, 3));
          1: p = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
          default: p = PRIO_W'($urandom);
        endcase
        issue_request(op, t, p);
        sent++;
      end
      if ($urandom_range(0, 2) == 0) wait_for_drain();
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_stable_ordering();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results: %0d pushes, %0d pops, %0d status reads.", results_seen,
             pushes_seen, pops_seen, status_seen);
    $display("Queue filled to %0d of %0d; %0d pushes hit a full queue, %0d pops an empty one.",
             max_fill, QUEUE_DEPTH, full_hits, empty_hits);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
